### rtl/core/dapg_pkg.sv
`timescale 1ns / 1ps
// Shared types for the drifting attractor point generator.
// Holds the datapath command codes and the controller/datapath structs; no dependencies.
package dapg_pkg;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_MUL_PHASE,
        OP_LOAD_R,
        OP_RED,
        OP_FOLD,
        OP_SQ,
        OP_Z,
        OP_DMUL,
        OP_DQ,
        OP_DCOR,
        OP_ZT,
        OP_NXT,
        OP_ST,
        OP_RES,
        OP_MX,
        OP_AX,
        OP_MY,
        OP_AY,
        OP_SX,
        OP_OX,
        OP_SY,
        OP_OY,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] sin_idx;
        logic [1:0] div_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic red_done;
    } dp_status_t;

    localparam logic [1:0] LAST_SIN = 2'd3;
    localparam logic [1:0] LAST_DIV = 2'd3;

endpackage

### rtl/core/drifting_attractor_point_generator_top.sv
`timescale 1ns / 1ps
// Top level of the drifting attractor point generator.
// Joins dapg_controller and dapg_datapath; depends on dapg_pkg.
//
//  Channel | Signals                                  | Direction
//  input   | in_valid, in_ready, op, drift_a..drift_d | request in
//  output  | out_valid, out_ready, point_x, point_y   | request out
//  config  | cfg_we, cfg_index, cfg_data              | write only
//
// A restart request gives no result.
// A compute request runs the four sine evaluations in turn on the one shared multiplier,
// and corrects each of the four phases by 2pi until it lies in [0, 2pi).
// Reset loads start values, scale, point and coefficients, and no other datapath register.
// A finished result waits in the output register; the next request is taken meanwhile and
// stalls only at its own end if the earlier result is still untaken.
module drifting_attractor_point_generator_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic signed [10:0] drift_a,
    input  logic signed [10:0] drift_b,
    input  logic signed [10:0] drift_c,
    input  logic signed [10:0] drift_d,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [11:0] point_x,
    output logic signed [11:0] point_y,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_data
);
    import dapg_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    dapg_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    dapg_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .op        (op),
        .drift_a   (drift_a),
        .drift_b   (drift_b),
        .drift_c   (drift_c),
        .drift_d   (drift_d),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .point_x   (point_x),
        .point_y   (point_y)
    );

endmodule

### rtl/core/dapg_datapath.sv
`timescale 1ns / 1ps
// Datapath of the attractor generator: configuration, map state, shared multiplier and sine steps.
// Depends on dapg_pkg for the command and status types.
module dapg_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dapg_pkg::dp_cmd_t     cmd,
    output dapg_pkg::dp_status_t  status,
    input  logic                  op,
    input  logic signed [10:0]    drift_a,
    input  logic signed [10:0]    drift_b,
    input  logic signed [10:0]    drift_c,
    input  logic signed [10:0]    drift_d,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [19:0]           cfg_data,
    output logic signed [11:0]    point_x,
    output logic signed [11:0]    point_y
);
    import dapg_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int SIN_SH = 30 - FRAC_BITS;
    localparam longint TWO_PI_L = (64'sd6746518852 + (64'sd1 <<< (SIN_SH - 1))) >>> SIN_SH;
    localparam longint PI_L = (64'sd3373259426 + (64'sd1 <<< (SIN_SH - 1))) >>> SIN_SH;
    localparam longint HALF_PI_L = (64'sd1686629713 + (64'sd1 <<< (SIN_SH - 1))) >>> SIN_SH;
    localparam logic signed [24:0] TWO_PI_Q = 25'(TWO_PI_L);
    localparam logic signed [24:0] PI_Q = 25'(PI_L);
    localparam logic signed [24:0] HALF_PI_Q = 25'(HALF_PI_L);
    localparam logic [31:0] ONE30 = 32'h4000_0000;
    localparam logic [32:0] SIN_ONE = 33'd1 << FRAC_BITS;
    localparam logic signed [24:0] Q_MAX = 25'sd524287;
    localparam logic signed [24:0] Q_MIN = -25'sd524288;
    localparam logic signed [13:0] OUT_MAX = 14'sd2047;

    localparam logic [2:0] REG_START_A = 3'd0;
    localparam logic [2:0] REG_START_B = 3'd1;
    localparam logic [2:0] REG_START_C = 3'd2;
    localparam logic [2:0] REG_START_D = 3'd3;
    localparam logic [2:0] REG_START_X = 3'd4;
    localparam logic [2:0] REG_START_Y = 3'd5;
    localparam logic [2:0] REG_OUTPUT_SCALE = 3'd6;

    function automatic logic [6:0] div_const(input logic [1:0] idx);
        case (idx)
            2'd0:    div_const = 7'd72;
            2'd1:    div_const = 7'd42;
            2'd2:    div_const = 7'd20;
            default: div_const = 7'd6;
        endcase
    endfunction

    function automatic logic [31:0] div_recip(input logic [1:0] idx);
        case (idx)
            2'd0:    div_recip = 32'd238609294;
            2'd1:    div_recip = 32'd409044504;
            2'd2:    div_recip = 32'd858993459;
            default: div_recip = 32'd2863311530;
        endcase
    endfunction

    function automatic logic signed [32:0] sx20(input logic signed [19:0] v);
        sx20 = {{13{v[19]}}, v};
    endfunction

    function automatic logic signed [19:0] sat20(input logic signed [24:0] v);
        if (v > Q_MAX)
            sat20 = 20'(Q_MAX);
        else if (v < Q_MIN)
            sat20 = 20'(Q_MIN);
        else
            sat20 = v[19:0];
    endfunction

    function automatic logic signed [19:0] add_drift(input logic signed [19:0] c,
                                                     input logic signed [10:0] d);
        logic signed [24:0] s;
        s = {{5{c[19]}}, c} + {{14{d[10]}}, d};
        add_drift = sat20(s);
    endfunction

    logic signed [19:0] start_a_reg, start_b_reg, start_c_reg, start_d_reg;
    logic signed [19:0] start_x_reg, start_y_reg;
    logic [7:0]         scale_reg;
    logic signed [19:0] cur_x_reg, cur_y_reg;
    logic signed [19:0] coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg;
    logic signed [10:0] dr_a_reg, dr_b_reg, dr_c_reg, dr_d_reg;

    logic signed [65:0] prod_reg;
    logic signed [24:0] r_reg;
    logic               neg_reg;
    logic [31:0]        r30_reg, z_reg, n_reg, q_reg, t_reg;
    logic signed [17:0] sin_reg [4];
    logic signed [11:0] px_reg, py_reg, point_x_reg, point_y_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic signed [24:0] r_next, r1, r2;
    logic               neg_next;
    logic [39:0]        qd, rem;
    logic [31:0]        qc, t_next;
    logic [32:0]        rnd;
    logic signed [17:0] sin_next;
    logic signed [24:0] comb_sum;
    logic signed [19:0] comb_sat;
    logic signed [29:0] scaled, scaled_adj;
    logic signed [13:0] scaled_int;
    logic signed [11:0] out_sat;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_PHASE:
            begin
                case (cmd.sin_idx)
                    2'd0:
                    begin
                        mul_a = sx20(coef_b_reg);
                        mul_b = sx20(cur_y_reg);
                    end
                    2'd1:
                    begin
                        mul_a = sx20(coef_b_reg);
                        mul_b = sx20(cur_x_reg);
                    end
                    2'd2:
                    begin
                        mul_a = sx20(coef_a_reg);
                        mul_b = sx20(cur_x_reg);
                    end
                    default:
                    begin
                        mul_a = sx20(coef_a_reg);
                        mul_b = sx20(cur_y_reg);
                    end
                endcase
            end
            OP_SQ:
            begin
                mul_a = {1'b0, r30_reg};
                mul_b = {1'b0, r30_reg};
            end
            OP_DMUL:
            begin
                mul_a = {1'b0, n_reg};
                mul_b = {1'b0, div_recip(cmd.div_idx)};
            end
            OP_ZT:
            begin
                mul_a = {1'b0, z_reg};
                mul_b = {1'b0, t_reg};
            end
            OP_ST:
            begin
                mul_a = {1'b0, r30_reg};
                mul_b = {1'b0, t_reg};
            end
            OP_MX:
            begin
                mul_a = sx20(coef_c_reg);
                mul_b = {{15{sin_reg[1][17]}}, sin_reg[1]};
            end
            OP_MY:
            begin
                mul_a = sx20(coef_d_reg);
                mul_b = {{15{sin_reg[3][17]}}, sin_reg[3]};
            end
            OP_SX:
            begin
                mul_a = sx20(cur_x_reg);
                mul_b = {25'b0, scale_reg};
            end
            OP_SY:
            begin
                mul_a = sx20(cur_y_reg);
                mul_b = {25'b0, scale_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        if (r_reg[24])
            r_next = r_reg + TWO_PI_Q;
        else if (r_reg >= TWO_PI_Q)
            r_next = r_reg - TWO_PI_Q;
        else
            r_next = r_reg;
        if (r_reg >= PI_Q)
        begin
            neg_next = 1'b1;
            r1 = r_reg - PI_Q;
        end
        else
        begin
            neg_next = 1'b0;
            r1 = r_reg;
        end
        if (r1 > HALF_PI_Q)
            r2 = PI_Q - r1;
        else
            r2 = r1;
        if (r2[24])
            r2 = '0;
    end

    assign status.red_done = !r_reg[24] && (r_reg < TWO_PI_Q);

    always_comb
    begin
        qd = {8'b0, q_reg} * {33'b0, div_const(cmd.div_idx)};
        rem = {8'b0, n_reg} - qd;
        qc = q_reg + ((rem >= {33'b0, div_const(cmd.div_idx)}) ? 32'd1 : 32'd0);
        t_next = ONE30 - qc;
        rnd = ({1'b0, prod_reg[61:30]} + (33'd1 << (SIN_SH - 1))) >> SIN_SH;
        if (rnd > SIN_ONE)
            rnd = SIN_ONE;
        sin_next = neg_reg ? -$signed(rnd[17:0]) : $signed(rnd[17:0]);
    end

    always_comb
    begin
        if (cmd.op == OP_AX)
            comb_sum = {{7{sin_reg[0][17]}}, sin_reg[0]}
                     + {prod_reg[FRAC_BITS+23], prod_reg[FRAC_BITS+23:FRAC_BITS]};
        else
            comb_sum = {{7{sin_reg[2][17]}}, sin_reg[2]}
                     + {prod_reg[FRAC_BITS+23], prod_reg[FRAC_BITS+23:FRAC_BITS]};
        comb_sat = sat20(comb_sum);
        scaled = prod_reg[29:0];
        scaled_adj = scaled[29] ? scaled + 30'sd65535 : scaled;
        scaled_int = scaled_adj[29:FRAC_BITS];
        if (scaled_int > OUT_MAX)
            out_sat = 12'(OUT_MAX);
        else if (scaled_int < -OUT_MAX)
            out_sat = 12'(-OUT_MAX);
        else
            out_sat = scaled_int[11:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_a_reg <= -20'sd63369;
            start_b_reg <= 20'sd188737;
            start_c_reg <= 20'sd50145;
            start_d_reg <= 20'sd48807;
            start_x_reg <= 20'sd6554;
            start_y_reg <= 20'sd6554;
            scale_reg   <= 8'd200;
            coef_a_reg  <= -20'sd63369;
            coef_b_reg  <= 20'sd188737;
            coef_c_reg  <= 20'sd50145;
            coef_d_reg  <= 20'sd48807;
            cur_x_reg   <= 20'sd6554;
            cur_y_reg   <= 20'sd6554;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_START_A:      start_a_reg <= cfg_data;
                    REG_START_B:      start_b_reg <= cfg_data;
                    REG_START_C:      start_c_reg <= cfg_data;
                    REG_START_D:      start_d_reg <= cfg_data;
                    REG_START_X:      start_x_reg <= cfg_data;
                    REG_START_Y:      start_y_reg <= cfg_data;
                    REG_OUTPUT_SCALE: scale_reg <= cfg_data[7:0];
                    default:          scale_reg <= scale_reg;
                endcase
            end
            case (cmd.op)
                OP_ACCEPT:
                begin
                    if (!op)
                    begin
                        coef_a_reg <= start_a_reg;
                        coef_b_reg <= start_b_reg;
                        coef_c_reg <= start_c_reg;
                        coef_d_reg <= start_d_reg;
                        cur_x_reg  <= start_x_reg;
                        cur_y_reg  <= start_y_reg;
                    end
                end
                OP_AX: cur_x_reg <= comb_sat;
                OP_AY: cur_y_reg <= comb_sat;
                OP_OUT:
                begin
                    coef_a_reg <= add_drift(coef_a_reg, dr_a_reg);
                    coef_b_reg <= add_drift(coef_b_reg, dr_b_reg);
                    coef_c_reg <= add_drift(coef_c_reg, dr_c_reg);
                    coef_d_reg <= add_drift(coef_d_reg, dr_d_reg);
                end
                default:
                begin
                    cur_x_reg <= cur_x_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACCEPT:
            begin
                dr_a_reg <= drift_a;
                dr_b_reg <= drift_b;
                dr_c_reg <= drift_c;
                dr_d_reg <= drift_d;
            end
            OP_MUL_PHASE, OP_SQ, OP_DMUL, OP_ZT, OP_ST, OP_MX, OP_MY, OP_SX, OP_SY:
                prod_reg <= prod;
            OP_LOAD_R:
                r_reg <= {prod_reg[FRAC_BITS+23], prod_reg[FRAC_BITS+23:FRAC_BITS]};
            OP_RED:
                r_reg <= r_next;
            OP_FOLD:
            begin
                neg_reg <= neg_next;
                r30_reg <= {r2[17:0], {SIN_SH{1'b0}}};
            end
            OP_Z:
            begin
                z_reg <= prod_reg[61:30];
                n_reg <= prod_reg[61:30];
            end
            OP_DQ:
                q_reg <= prod_reg[65:34];
            OP_DCOR:
                t_reg <= t_next;
            OP_NXT:
                n_reg <= prod_reg[61:30];
            OP_RES:
                sin_reg[cmd.sin_idx] <= sin_next;
            OP_OX:
                px_reg <= out_sat;
            OP_OY:
                py_reg <= out_sat;
            OP_OUT:
            begin
                point_x_reg <= px_reg;
                point_y_reg <= py_reg;
            end
            default:
                neg_reg <= neg_reg;
        endcase
    end

    assign point_x = point_x_reg;
    assign point_y = point_y_reg;

endmodule

### rtl/core/dapg_controller.sv
`timescale 1ns / 1ps
// Sequencing state machine for the attractor generator: handshakes and datapath commands.
// Depends on dapg_pkg for the command and status types.
module dapg_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  op,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  dapg_pkg::dp_status_t  status,
    output dapg_pkg::dp_cmd_t     cmd
);
    import dapg_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_PH_MUL, S_PH_LOAD, S_RED, S_FOLD, S_SQ, S_Z, S_DMUL, S_DQ, S_DCOR,
        S_ZT, S_NXT, S_ST, S_RES, S_MX, S_AX, S_MY, S_AY, S_SX, S_OX, S_SY, S_OY, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] sin_idx_reg, sin_idx_next;
    logic [1:0] div_idx_reg, div_idx_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        sin_idx_next = sin_idx_reg;
        div_idx_next = div_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op = OP_NOP;
        cmd.sin_idx = sin_idx_reg;
        cmd.div_idx = div_idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_ACCEPT;
                    if (op)
                    begin
                        state_next = S_PH_MUL;
                        sin_idx_next = 2'd0;
                    end
                end
            end
            S_PH_MUL:
            begin
                cmd.op = OP_MUL_PHASE;
                state_next = S_PH_LOAD;
            end
            S_PH_LOAD:
            begin
                cmd.op = OP_LOAD_R;
                state_next = S_RED;
            end
            S_RED:
            begin
                cmd.op = OP_RED;
                if (status.red_done)
                    state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.op = OP_FOLD;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.op = OP_SQ;
                state_next = S_Z;
            end
            S_Z:
            begin
                cmd.op = OP_Z;
                div_idx_next = 2'd0;
                state_next = S_DMUL;
            end
            S_DMUL:
            begin
                cmd.op = OP_DMUL;
                state_next = S_DQ;
            end
            S_DQ:
            begin
                cmd.op = OP_DQ;
                state_next = S_DCOR;
            end
            S_DCOR:
            begin
                cmd.op = OP_DCOR;
                state_next = (div_idx_reg == LAST_DIV) ? S_ST : S_ZT;
            end
            S_ZT:
            begin
                cmd.op = OP_ZT;
                state_next = S_NXT;
            end
            S_NXT:
            begin
                cmd.op = OP_NXT;
                div_idx_next = div_idx_reg + 2'd1;
                state_next = S_DMUL;
            end
            S_ST:
            begin
                cmd.op = OP_ST;
                state_next = S_RES;
            end
            S_RES:
            begin
                cmd.op = OP_RES;
                if (sin_idx_reg == LAST_SIN)
                    state_next = S_MX;
                else
                begin
                    sin_idx_next = sin_idx_reg + 2'd1;
                    state_next = S_PH_MUL;
                end
            end
            S_MX:
            begin
                cmd.op = OP_MX;
                state_next = S_AX;
            end
            S_AX:
            begin
                cmd.op = OP_AX;
                state_next = S_MY;
            end
            S_MY:
            begin
                cmd.op = OP_MY;
                state_next = S_AY;
            end
            S_AY:
            begin
                cmd.op = OP_AY;
                state_next = S_SX;
            end
            S_SX:
            begin
                cmd.op = OP_SX;
                state_next = S_OX;
            end
            S_OX:
            begin
                cmd.op = OP_OX;
                state_next = S_SY;
            end
            S_SY:
            begin
                cmd.op = OP_SY;
                state_next = S_OY;
            end
            S_OY:
            begin
                cmd.op = OP_OY;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sin_idx_reg   <= 2'd0;
            div_idx_reg   <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sin_idx_reg   <= sin_idx_next;
            div_idx_reg   <= div_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_compute_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op |=> state_reg == S_PH_MUL)
        else $error("compute request did not start the sine sequence");

    a_out_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && out_valid_reg && !out_ready |=> state_reg == S_OUT)
        else $error("new result overwrote an untaken result");

    a_last_sine: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RES && sin_idx_reg == LAST_SIN |=> state_reg == S_MX)
        else $error("combine step did not follow the fourth sine");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

endmodule

### tb/dapg_tb_pkg.sv
`timescale 1ns / 1ps
// Register indexes and request codes shared by the testbench files.
// No dependencies.
package dapg_tb_pkg;

    typedef enum logic [2:0] {
        REG_START_A,
        REG_START_B,
        REG_START_C,
        REG_START_D,
        REG_START_X,
        REG_START_Y,
        REG_OUTPUT_SCALE
    } cfg_reg_t;

    typedef enum logic {
        REQ_RESTART,
        REQ_STEP
    } req_kind_t;

    localparam logic signed [19:0] START_A_RST = -20'sd63369;
    localparam logic signed [19:0] START_B_RST = 20'sd188737;
    localparam logic signed [19:0] START_C_RST = 20'sd50145;
    localparam logic signed [19:0] START_D_RST = 20'sd48807;
    localparam logic signed [19:0] START_X_RST = 20'sd6554;
    localparam logic signed [19:0] START_Y_RST = 20'sd6554;
    localparam logic [7:0]         SCALE_RST   = 8'd200;

endpackage

### tb/dapg_checker.sv
`timescale 1ns / 1ps
// Watches the request, result and register channels, predicts each point and compares.
// Depends on dapg_tb_pkg.
module dapg_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               op,
    input  logic signed [10:0] drift_a,
    input  logic signed [10:0] drift_b,
    input  logic signed [10:0] drift_c,
    input  logic signed [10:0] drift_d,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [11:0] point_x,
    input  logic signed [11:0] point_y,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_data,
    output int                 errors,
    output int                 outstanding
);
    import dapg_tb_pkg::*;

    localparam int    FRAC     = 16;
    localparam int    SH       = 30 - FRAC;
    localparam longint QMAX    = 524287;
    localparam longint QMIN    = -524288;
    localparam longint TWO_PI30  = 64'd6746518852;
    localparam longint PI30      = 64'd3373259426;
    localparam longint HALF_PI30 = 64'd1686629713;

    typedef struct {
        logic signed [11:0] x;
        logic signed [11:0] y;
    } point_t;

    point_t expected_points[$];

    longint start_q[6];
    longint scale;
    longint cur_x, cur_y, ca, cb, cc, cd;

    function automatic longint round_q(longint c30);
        return (c30 + (longint'(1) << (SH - 1))) >>> SH;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint fmul(longint p, longint q);
        return (p * q) >>> FRAC;
    endfunction

    function automatic longint sine_q(longint ph);
        longint two_pi, pi, half_pi, r;
        bit neg;
        longint unsigned r30, z, t, s30, res;
        two_pi  = round_q(TWO_PI30);
        pi      = round_q(PI30);
        half_pi = round_q(HALF_PI30);
        neg = 0;
        r = ph % two_pi;
        if (r < 0)
            r += two_pi;
        if (r >= pi)
        begin
            neg = 1;
            r -= pi;
        end
        if (r > half_pi)
            r = pi - r;
        if (r < 0)
            r = 0;
        r30 = longint'(r) << SH;
        z = (r30 * r30) >> 30;
        t = (64'd1 << 30) - z / 72;
        t = (64'd1 << 30) - ((z * t) >> 30) / 42;
        t = (64'd1 << 30) - ((z * t) >> 30) / 20;
        t = (64'd1 << 30) - ((z * t) >> 30) / 6;
        s30 = (r30 * t) >> 30;
        res = (s30 + (64'd1 << (SH - 1))) >> SH;
        if (res > (64'd1 << FRAC))
            res = 64'd1 << FRAC;
        return neg ? -longint'(res) : longint'(res);
    endfunction

    function automatic logic signed [11:0] scale_point(longint v);
        longint p, m;
        p = v * scale;
        m = (p >= 0) ? (p >>> FRAC) : -((-p) >>> FRAC);
        return 12'(clamp(m, -2047, 2047));
    endfunction

    task automatic report(string msg);
        $display("%0t: %s", $time, msg);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        longint nx, ny;
        point_t pt;
        if (!rst_n)
        begin
            errors = 0;
            expected_points.delete();
            start_q = '{START_A_RST, START_B_RST, START_C_RST, START_D_RST,
                        START_X_RST, START_Y_RST};
            scale = SCALE_RST;
            ca = START_A_RST; cb = START_B_RST; cc = START_C_RST; cd = START_D_RST;
            cur_x = START_X_RST; cur_y = START_Y_RST;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_points.size() == 0)
                    report($sformatf("point (%0d, %0d) with none expected", point_x, point_y));
                else
                begin
                    pt = expected_points.pop_front();
                    if (point_x !== pt.x)
                        report($sformatf("point_x mismatch: got %0d, expected %0d",
                                         point_x, pt.x));
                    if (point_y !== pt.y)
                        report($sformatf("point_y mismatch: got %0d, expected %0d",
                                         point_y, pt.y));
                end
            end
            if (in_valid && in_ready)
            begin
                if (op == REQ_RESTART)
                begin
                    ca = start_q[0]; cb = start_q[1]; cc = start_q[2]; cd = start_q[3];
                    cur_x = start_q[4]; cur_y = start_q[5];
                end
                else
                begin
                    nx = sine_q(fmul(cb, cur_y)) + fmul(cc, sine_q(fmul(cb, cur_x)));
                    ny = sine_q(fmul(ca, cur_x)) + fmul(cd, sine_q(fmul(ca, cur_y)));
                    cur_x = clamp(nx, QMIN, QMAX);
                    cur_y = clamp(ny, QMIN, QMAX);
                    pt.x = scale_point(cur_x);
                    pt.y = scale_point(cur_y);
                    expected_points = {expected_points, pt};
                    ca = clamp(ca + drift_a, QMIN, QMAX);
                    cb = clamp(cb + drift_b, QMIN, QMAX);
                    cc = clamp(cc + drift_c, QMIN, QMAX);
                    cd = clamp(cd + drift_d, QMIN, QMAX);
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_OUTPUT_SCALE)
                    scale = cfg_data[7:0];
                else if (cfg_index < REG_OUTPUT_SCALE)
                    start_q[cfg_index] = longint'(signed'(cfg_data));
            end
            outstanding = expected_points.size();
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Top of the attractor generator testbench: clock, reset, requests, register phases and verdict.
// Depends on dapg_tb_pkg, dapg_checker and the block itself.
module testbench;
    import dapg_tb_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               op;
    logic signed [10:0] drift_a, drift_b, drift_c, drift_d;
    logic               out_valid;
    logic               out_ready;
    logic signed [11:0] point_x, point_y;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [19:0]        cfg_data;
    int                 errors;
    int                 outstanding;
    int                 sender_idle;
    int                 receiver_idle;
    bit                 hold_request;
    int                 hold_left;
    int                 quiet_cycles;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int SETTLE_CYCLES  = 250;

    drifting_attractor_point_generator_top u_dut (.*);

    dapg_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= receiver_idle);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else if (++quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_request(req_kind_t kind, logic signed [10:0] da, logic signed [10:0] db,
                                logic signed [10:0] dc, logic signed [10:0] dd);
        while ($urandom_range(99) < sender_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= kind;
        drift_a  <= da;
        drift_b  <= db;
        drift_c  <= dc;
        drift_d  <= dd;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_random(int restart_pct);
        logic signed [10:0] d[4];
        foreach (d[i])
            case ($urandom_range(7))
                0: d[i] = 11'sh3ff;
                1: d[i] = -11'sh400;
                default: d[i] = 11'($urandom);
            endcase
        send_request(($urandom_range(99) < restart_pct) ? REQ_RESTART : REQ_STEP,
                     d[0], d[1], d[2], d[3]);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [19:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(int kind, int count);
        logic [19:0] q[6];
        logic [7:0]  sc;
        settle();
        foreach (q[i])
            q[i] = (kind == 1) ? 20'h7ffff : (kind == 2) ? 20'h80000 : 20'($urandom);
        sc = (kind == 1) ? 8'd255 : (kind == 2) ? 8'd0 : (kind == 3) ? 8'd1 : 8'($urandom);
        write_reg(REG_START_A, q[0]);
        write_reg(REG_START_B, q[1]);
        write_reg(REG_START_C, q[2]);
        write_reg(REG_START_D, q[3]);
        write_reg(REG_START_X, q[4]);
        write_reg(REG_START_Y, q[5]);
        write_reg(REG_OUTPUT_SCALE, sc);
        send_request(REQ_STEP, 0, 0, 0, 0);
        send_request(REQ_RESTART, 11'sh3ff, -11'sh400, 11'sh155, -11'sh2ab);
        repeat (count)
            send_random(6);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = REQ_RESTART;
        drift_a = '0;
        drift_b = '0;
        drift_c = '0;
        drift_d = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_START_A;
        cfg_data = '0;
        sender_idle = 20;
        receiver_idle = 54;
        hold_request = 1'b0;
        hold_left = 0;
        quiet_cycles = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_request(REQ_STEP, 0, 0, 0, 0);
        send_request(REQ_STEP, 11'sh3ff, 11'sh3ff, 11'sh3ff, 11'sh3ff);
        send_request(REQ_STEP, -11'sh400, -11'sh400, -11'sh400, -11'sh400);
        send_request(REQ_RESTART, -11'sh400, 11'sh3ff, -11'sh400, 11'sh3ff);
        send_request(REQ_RESTART, 0, 0, 0, 0);
        repeat (6)
            send_request(REQ_STEP, 11'sh3ff, -11'sh400, 11'sh3ff, -11'sh400);
        send_request(REQ_RESTART, 0, 0, 0, 0);
        repeat (4)
            send_random(0);

        run_phase(1, 200);
        run_phase(2, 200);
        run_phase(0, 200);
        sender_idle = 54;
        receiver_idle = 20;
        run_phase(3, 200);
        run_phase(0, 200);
        run_phase(0, 200);
        sender_idle = 0;
        receiver_idle = 0;
        run_phase(0, 200);
        hold_request = 1'b1;
        repeat (300)
            send_random(6);

        settle();
        if (errors == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
